// ===== rtl/abkf_pkg.sv =====
// ----------------------------------------------------------------------------
// abkf_pkg
// shared types, constants and helpers for the angle/bias kalman filter
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam logic [1:0] CFG_PN_ANGLE = 2'd0;
    localparam logic [1:0] CFG_PN_BIAS  = 2'd1;
    localparam logic [1:0] CFG_MEAS_N   = 2'd2;

    localparam logic [30:0] PN_ANGLE_RST = 31'd268435;
    localparam logic [30:0] PN_BIAS_RST  = 31'd805306;
    localparam logic [30:0] MEAS_N_RST   = 31'd8053064;

    // one multiply/accumulate step of the filter
    typedef enum logic [3:0] {
        ST_ANGLE,
        ST_DTP11,
        ST_P00,
        ST_P11,
        ST_ANG_C,
        ST_BIAS_C,
        ST_C00,
        ST_C01,
        ST_C10,
        ST_C11
    } step_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIV,
        S_DIVW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  acc;
        logic  div_start;
        logic  out_load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [31:0] r;
        if (x > 72'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/abkf_div.sv =====
// ----------------------------------------------------------------------------
// abkf_div
// serial signed divider: sat32((num * 2^28) / den), truncating, one bit a cycle
// ----------------------------------------------------------------------------
module abkf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [33:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    import abkf_pkg::*;

    logic        busy_reg, done_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] rem_reg, dmag_reg;
    logic [31:0] nlow_reg, q_reg;
    logic        neg_reg, ovf_reg;

    logic [31:0] num_abs;
    logic [33:0] den_abs;
    logic [34:0] rem2;
    logic        take;

    assign num_abs = num[31] ? (~num + 32'd1) : num;
    assign den_abs = den[33] ? (~den + 34'd1) : den;
    assign rem2    = {rem_reg, nlow_reg[31]};
    assign take    = rem2 >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            dmag_reg <= den_abs;
            neg_reg  <= num[31] ^ den[33];
            q_reg    <= '0;
            rem_reg  <= {6'd0, num_abs[31:4]};
            nlow_reg <= {num_abs[3:0], 28'd0};
            // zero divisor gives a zero gain
            if (den == '0)
            begin
                ovf_reg  <= 1'b0;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if ({6'd0, num_abs} >= {den_abs, 4'd0})
            begin
                ovf_reg  <= 1'b1;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                ovf_reg  <= 1'b0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? 34'(rem2 - {1'b0, dmag_reg}) : rem2[33:0];
            nlow_reg <= {nlow_reg[30:0], 1'b0};
            q_reg    <= {q_reg[30:0], take};
            cnt_reg  <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!neg_reg)
            quot = (ovf_reg || q_reg[31]) ? 32'sh7fffffff : q_reg;
        else if (ovf_reg || (q_reg > 32'h80000000))
            quot = 32'sh80000000;
        else
            quot = ~q_reg + 32'd1;
    end

    assign done = done_reg;

endmodule

// ===== rtl/abkf_datapath.sv =====
// ----------------------------------------------------------------------------
// abkf_datapath
// state, noise registers, shared multiplier and the two gain dividers
// ----------------------------------------------------------------------------
module abkf_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  abkf_pkg::cmd_t     cmd,
    output abkf_pkg::status_t  status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] measured_rate,
    input  logic [23:0]        time_step,
    output logic signed [31:0] filtered_angle,
    output logic signed [31:0] unbiased_rate
);
    import abkf_pkg::*;

    logic [30:0] pna_reg, pnb_reg, mn_reg;
    logic signed [31:0] ang_reg, bias_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, rate_reg, y_reg;
    logic signed [33:0] inner_reg;
    logic [23:0]        dt_reg;
    logic signed [66:0] prod_reg;
    logic signed [31:0] fa_reg, ur_reg;

    logic signed [33:0] op_a;
    logic signed [32:0] op_b;
    logic signed [33:0] dt_a;
    logic signed [32:0] dt_b;
    logic signed [71:0] p24, p28;
    logic signed [71:0] dtp11;
    logic signed [31:0] k0, k1;
    logic               d0, d1;
    logic signed [33:0] den;

    assign dt_a = {10'd0, dt_reg};
    assign dt_b = {9'd0, dt_reg};
    assign p24  = {{29{prod_reg[66]}}, prod_reg[66:24]};
    assign p28  = {{33{prod_reg[66]}}, prod_reg[66:28]};
    assign dtp11 = p24;
    assign den  = {{2{p00_reg[31]}}, p00_reg} + {3'd0, mn_reg};

    always_comb
    begin
        case (cmd.step)
            ST_ANGLE:  begin op_a = dt_a;  op_b = {rate_reg[31], rate_reg}; end
            ST_DTP11:  begin op_a = dt_a;  op_b = {c11_reg[31], c11_reg}; end
            ST_P00:    begin op_a = inner_reg; op_b = dt_b; end
            ST_P11:    begin op_a = {3'd0, pnb_reg}; op_b = dt_b; end
            ST_ANG_C:  begin op_a = {{2{k0[31]}}, k0}; op_b = {y_reg[31], y_reg}; end
            ST_BIAS_C: begin op_a = {{2{k1[31]}}, k1}; op_b = {y_reg[31], y_reg}; end
            ST_C00:    begin op_a = {{2{k0[31]}}, k0}; op_b = {p00_reg[31], p00_reg}; end
            ST_C01:    begin op_a = {{2{k0[31]}}, k0}; op_b = {p01_reg[31], p01_reg}; end
            ST_C10:    begin op_a = {{2{k1[31]}}, k1}; op_b = {p00_reg[31], p00_reg}; end
            ST_C11:    begin op_a = {{2{k1[31]}}, k1}; op_b = {p01_reg[31], p01_reg}; end
            default:   begin op_a = '0; op_b = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= op_a * op_b;
    end

    // noise registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pna_reg <= PN_ANGLE_RST;
            pnb_reg <= PN_BIAS_RST;
            mn_reg  <= MEAS_N_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PN_ANGLE: pna_reg <= cfg_data[30:0];
                CFG_PN_BIAS:  pnb_reg <= cfg_data[30:0];
                CFG_MEAS_N:   mn_reg  <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg  <= '0;
            bias_reg <= '0;
            c00_reg  <= '0;
            c01_reg  <= '0;
            c10_reg  <= '0;
            c11_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            case (cmd.step)
                ST_ANGLE:  ang_reg  <= sat32({{40{ang_reg[31]}}, ang_reg} + p24);
                ST_ANG_C:  ang_reg  <= sat32({{40{ang_reg[31]}}, ang_reg} + p28);
                ST_BIAS_C: bias_reg <= sat32({{40{bias_reg[31]}}, bias_reg} + p28);
                ST_C00:    c00_reg  <= sat32({{40{p00_reg[31]}}, p00_reg} - p28);
                ST_C01:    c01_reg  <= sat32({{40{p01_reg[31]}}, p01_reg} - p28);
                ST_C10:    c10_reg  <= sat32({{40{p10_reg[31]}}, p10_reg} - p28);
                ST_C11:    c11_reg  <= sat32({{40{p11_reg[31]}}, p11_reg} - p28);
                default:   ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= measured_angle;
            dt_reg   <= time_step;
            rate_reg <= sat32({{40{measured_rate[31]}}, measured_rate}
                              - {{40{bias_reg[31]}}, bias_reg});
        end
        if (cmd.acc)
        begin
            case (cmd.step)
                ST_DTP11:
                begin
                    p01_reg   <= sat32({{40{c01_reg[31]}}, c01_reg} - dtp11);
                    p10_reg   <= sat32({{40{c10_reg[31]}}, c10_reg} - dtp11);
                    inner_reg <= 34'(dtp11 - {{40{c01_reg[31]}}, c01_reg}
                                 - {{40{c10_reg[31]}}, c10_reg} + {41'd0, pna_reg});
                end
                ST_P00: p00_reg <= sat32({{40{c00_reg[31]}}, c00_reg} + p24);
                ST_P11: p11_reg <= sat32({{40{c11_reg[31]}}, c11_reg} + p24);
                default: ;
            endcase
        end
        if (cmd.div_start)
            y_reg <= sat32({{40{meas_reg[31]}}, meas_reg} - {{40{ang_reg[31]}}, ang_reg});
        if (cmd.out_load)
        begin
            fa_reg <= ang_reg;
            ur_reg <= rate_reg;
        end
    end

    abkf_div u_div_k0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (p00_reg),
        .den   (den),
        .done  (d0),
        .quot  (k0)
    );

    abkf_div u_div_k1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (p10_reg),
        .den   (den),
        .done  (d1),
        .quot  (k1)
    );

    assign status.div_done = d0 & d1;
    assign filtered_angle  = fa_reg;
    assign unbiased_rate   = ur_reg;

endmodule

// ===== rtl/abkf_ctrl.sv =====
// ----------------------------------------------------------------------------
// abkf_ctrl
// sequencer for predict, gain division, correct and result handoff
// ----------------------------------------------------------------------------
module abkf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output abkf_pkg::cmd_t    cmd,
    input  abkf_pkg::status_t status
);
    import abkf_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_ANGLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        ov_next       = ov_reg && !out_ready;
        cmd           = '0;
        cmd.step      = step_reg;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = ST_ANGLE;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == ST_P11)
                    state_next = S_DIV;
                else if (step_reg == ST_C11)
                    state_next = S_OUT;
                else
                begin
                    step_next  = step_t'(step_reg + 4'd1);
                    state_next = S_MUL;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (status.div_done)
                begin
                    step_next  = ST_ANG_C;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                // hold until the previous word has left the output register
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

endmodule

// ===== rtl/angle_bias_kalman_filter_core.sv =====
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// two-state tilt kalman filter tracking angle and gyro bias in fixed point
// ----------------------------------------------------------------------------
// One word in gives one word out. An item runs ten multiply steps on one
// shared multiplier (four predict, six correct), each a multiply state and an
// accumulate state. After the predict steps it starts the gain division and
// waits while two bit-serial dividers run side by side (32 bit steps) until
// both are done; then come the correct steps and the load of the output
// register. The dividers set most of the latency; when the divisor is zero or
// the gain saturates they finish at once. The core is back in idle as the
// result is loaded, and a new word is taken only once the previous item is
// through. The next word is taken while the previous result still sits in
// the output register; if the consumer has not taken that result by the time
// the next one is ready, the sequencer holds until it does, and no further
// input is taken meanwhile. Angles and rates are signed Q16.16, the time step
// unsigned Q0.24, covariances and noise values Q4.28; every result saturates.
// Noise registers sit on the cfg port (index 0 angle process noise, 1 bias
// process noise, 2 measurement noise; others ignored) and should be written
// only while the block is idle.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_core (
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] measured_rate,
    input  logic [23:0]        time_step,
    // result words
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_angle,
    output logic signed [31:0] unbiased_rate,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import abkf_pkg::*;

    cmd_t    cmd;
    status_t status;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    abkf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    abkf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_angle (measured_angle),
        .measured_rate  (measured_rate),
        .time_step      (time_step),
        .filtered_angle (filtered_angle),
        .unbiased_rate  (unbiased_rate)
    );

endmodule
